// File: hw/rtl/gr_enc_pkg.sv
// shared widths, constants and controller/datapath command and status types
// for the golomb-rice encoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gr_enc_pkg;

    localparam int VALUE_W  = 64;
    localparam int PARAM_W  = 6;
    localparam int BYTE_W   = 8;
    localparam int QUOT_W   = 8;

    localparam logic [PARAM_W-1:0] RICE_PARAM_RESET = 6'd19;
    localparam logic [QUOT_W-1:0]  MAX_QUOTIENT     = 8'd255;

    typedef struct packed {
        logic load;
        logic step;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: hw/rtl/gr_enc_datapath.sv
// datapath: rice parameter, held bits, code word counters and output register
// depends on gr_enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gr_enc_datapath import gr_enc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [PARAM_W-1:0] i_cfg_wr_data,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic               i_flush,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_status              o_status,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output logic [BYTE_W-1:0]       o_out_byte,
    output logic                    o_out_last,
    output logic                    o_out_ovf
);

    logic [PARAM_W-1:0] r_param;
    logic [6:0]         r_acc_bits;
    logic [2:0]         r_acc_cnt;
    logic [QUOT_W-1:0]  r_ones;
    logic               r_zp;
    logic [6:0]         r_rem_left;
    logic [VALUE_W-1:0] r_rem;
    logic               r_ovf;
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_last;
    logic               r_out_ovf;

    logic [VALUE_W-1:0] quot_full;
    logic               quot_big;
    logic [6:0]         rem_shamt;
    logic [VALUE_W-1:0] rem_load;
    logic [8:0]         remaining;
    logic [3:0]         room;
    logic               fits;
    logic [3:0]         consumed;
    logic [3:0]         dec_ones;
    logic [3:0]         c2;
    logic               zc;
    logic [3:0]         c3;
    logic [2:0]         sel [8];
    logic [7:0]         rem_top;
    logic [7:0]         win;
    logic [14:0]        joined;
    logic [7:0]         step_byte;
    logic [2:0]         tot;
    logic [6:0]         left_bits;
    logic               out_free;

    // load side
    assign quot_full = i_value >> r_param;
    assign quot_big  = quot_full > VALUE_W'(MAX_QUOTIENT);
    assign rem_shamt = 7'(VALUE_W) - {1'b0, r_param};
    assign rem_load  = (r_param == '0) ? '0 : (i_value << rem_shamt);

    // step side
    assign remaining = {1'b0, r_ones} + 9'(r_zp) + {2'b0, r_rem_left};
    assign room      = 4'd8 - {1'b0, r_acc_cnt};
    assign fits      = remaining >= {5'b0, room};
    assign consumed  = fits ? room : remaining[3:0];
    assign dec_ones  = (r_ones < QUOT_W'(consumed)) ? r_ones[3:0] : consumed;
    assign c2        = consumed - dec_ones;
    assign zc        = r_zp && (c2 != 4'd0);
    assign c3        = c2 - 4'(zc);
    assign rem_top   = r_rem[VALUE_W-1 -: 8];

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            sel[j] = 3'(9'(j) - {1'b0, r_ones} - 9'(r_zp));
            if (9'(j) < {1'b0, r_ones}) begin
                win[7-j] = 1'b1;
            end else if (r_zp && (9'(j) == {1'b0, r_ones})) begin
                win[7-j] = 1'b0;
            end else begin
                win[7-j] = rem_top[3'd7 - sel[j]];
            end
        end
    end

    assign joined    = {r_acc_bits, win};
    assign step_byte = 8'(joined >> r_acc_cnt);
    assign tot       = r_acc_cnt + remaining[2:0];
    assign left_bits = 7'(step_byte >> (4'd8 - {1'b0, tot}));
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_param     <= RICE_PARAM_RESET;
            r_acc_bits  <= '0;
            r_acc_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_param <= i_cfg_wr_data;
            end
            if (i_cmd.step && (r_ovf || fits)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.step && !r_ovf) begin
                if (fits) begin
                    r_acc_bits <= '0;
                    r_acc_cnt  <= '0;
                end else begin
                    r_acc_bits <= left_bits;
                    r_acc_cnt  <= tot;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_flush) begin
                // pad the held bits out to a byte with zeros
                r_ones     <= '0;
                r_zp       <= 1'b0;
                r_rem_left <= (r_acc_cnt == '0) ? 7'd0 : 7'(room);
                r_rem      <= '0;
                r_ovf      <= 1'b0;
            end else begin
                r_ones     <= quot_full[QUOT_W-1:0];
                r_zp       <= 1'b1;
                r_rem_left <= 7'(r_param);
                r_rem      <= rem_load;
                r_ovf      <= quot_big;
            end
        end else if (i_cmd.step && !r_ovf) begin
            r_ones     <= r_ones - QUOT_W'(dec_ones);
            r_zp       <= r_zp && !zc;
            r_rem_left <= r_rem_left - 7'(c3);
            r_rem      <= r_rem << c3;
        end
        if (i_cmd.step && out_free) begin
            r_out_byte <= r_ovf ? 8'd0 : step_byte;
            // last full byte when fewer than eight bits are left after it, or on overflow
            r_out_last <= r_ovf || (remaining < ({5'b0, room} + 9'd8));
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_status.done     = r_ovf || (remaining <= {5'b0, room});
    assign o_status.out_free = out_free;
    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_out_last        = r_out_last;
    assign o_out_ovf         = r_out_ovf;

endmodule

`default_nettype wire

// File: hw/rtl/gr_enc_ctrl.sv
// controller: accepts one item, then steps the packer once per cycle while the output is free
// depends on gr_enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gr_enc_ctrl import gr_enc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;
    logic   r_ready;

    assign o_cmd.load = i_in_valid && r_ready;
    assign o_cmd.step = (r_state == ST_RUN) && i_status.out_free;
    assign o_in_ready = r_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ready <= 1'b1;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_cmd.load) begin
                        r_state <= ST_RUN;
                        r_ready <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (o_cmd.step && i_status.done) begin
                        r_state <= ST_IDLE;
                        r_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_ready <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/golomb_rice_encoder.sv
// golomb-rice encoder top level: controller plus packing datapath
// depends on gr_enc_pkg, gr_enc_ctrl, gr_enc_datapath
//
// channel   | dir | payload                         | transfer
// s_axis    | in  | tdata value[63:0], tuser flush  | tvalid & tready
// m_axis    | out | tdata byte[7:0], tlast, tuser   | tvalid & tready
// cfg       | in  | i_cfg_wr_data rice parameter    | i_cfg_wr_en
//
// an item is accepted, then the packer takes one step per output byte, plus one more
// step when bits are left over or no byte comes out
// the packer in the datapath emits a byte per cycle while m_axis does not stall
// m_axis stalls hold the packer; the last byte can wait while a new item is taken
// synchronous active-low reset clears held bits and sets the parameter to 19
`timescale 1ns / 1ps
`default_nettype none

module golomb_rice_encoder import gr_enc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [PARAM_W-1:0] i_cfg_wr_data,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [VALUE_W-1:0] s_axis_tdata,   // value[63:0]
    input  wire logic               s_axis_tuser,   // flush
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [BYTE_W-1:0]       m_axis_tdata,   // out_byte[7:0]
    output logic                    m_axis_tlast,
    output logic                    m_axis_tuser    // overflow
);

    t_dp_cmd    cmd;
    t_dp_status status;

    gr_enc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gr_enc_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_value       (s_axis_tdata),
        .i_flush       (s_axis_tuser),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_byte    (m_axis_tdata),
        .o_out_last    (m_axis_tlast),
        .o_out_ovf     (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: hw/rtl/gr_enc_checker.sv
// port-level checks for the golomb-rice encoder, bound to the top level
// depends on gr_enc_pkg
`timescale 1ns / 1ps
`default_nettype none

module gr_enc_checker import gr_enc_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [BYTE_W-1:0] m_axis_tdata,
    input wire logic              m_axis_tlast,
    input wire logic              m_axis_tuser
);

    a_ovf_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0 && m_axis_tlast)
        else $error("overflow result must be a zero byte marked last");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after a transfer");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output changed");

endmodule

bind golomb_rice_encoder gr_enc_checker u_gr_enc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
